// File: sv/rgtl_pkg.sv
// Package for the rectangle tile layout block.
// Holds widths, register indexes, shared structs and the sequencer state type.
// Used by every module of the block; depends on nothing.
package rgtl_pkg;

  localparam int MAX_TILES = 64;
  localparam int CNT_W     = 7;
  localparam int IDX_W     = 6;
  localparam int COORD_W   = 16;
  localparam int POS_W     = 17;
  localparam int SIZE_W    = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int DIV_W      = SIZE_W;
  localparam int DSR_W      = CNT_W;
  localparam int DIV_STEPS  = DIV_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AREA_X      = 3'd0,
    REG_AREA_Y      = 3'd1,
    REG_AREA_WIDTH  = 3'd2,
    REG_AREA_HEIGHT = 3'd3,
    REG_ROW_COUNT   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] area_x;
    logic [COORD_W-1:0] area_y;
    logic [SIZE_W-1:0]  area_width;
    logic [SIZE_W-1:0]  area_height;
    logic [CNT_W-1:0]   row_count;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] tiles;
    logic [CNT_W-1:0] rows;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_N,
    ST_DIV_WMAX,
    ST_DIV_WMIN,
    ST_DIV_H,
    ST_EMIT
  } back_state_t;

endpackage

// File: sv/rect_grid_tile_layout.sv
// Top level of the rectangle tile layout block: configuration registers,
// front end, command queue and sequencer.
// Depends on rgtl_pkg, rgtl_front, rgtl_queue and rgtl_back.
//
//   Channel   Signals                                   Handshake
//   config    cfg_write, cfg_index, cfg_data            written when cfg_write is high
//   item in   start, tile_count, busy                   taken when start && !busy
//   tile out  result_strobe, tile_index .. is_last      one cycle per tile, no stall
//
// A pass runs four 15-step divisions on the shared restoring divider,
// then emits one tile per cycle from the sequencer.
// A two-entry queue lets the front end take items while the sequencer works;
// busy is high while the queue is full. A tile count of zero yields no tile.
// Reset is synchronous; it empties the queue and loads the register defaults.
module rect_grid_tile_layout (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rgtl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgtl_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic                                start,
  input  logic [rgtl_pkg::CNT_W-1:0]          tile_count,
  output logic                                busy,
  output logic                                result_strobe,
  output logic [rgtl_pkg::IDX_W-1:0]          tile_index,
  output logic signed [rgtl_pkg::POS_W-1:0]   tile_x,
  output logic signed [rgtl_pkg::POS_W-1:0]   tile_y,
  output logic [rgtl_pkg::SIZE_W-1:0]         tile_width,
  output logic [rgtl_pkg::SIZE_W-1:0]         tile_height,
  output logic                                is_last
);

  rgtl_pkg::cfg_t cfg;
  rgtl_pkg::cmd_t push_cmd;
  rgtl_pkg::cmd_t head;
  logic           push;
  logic           pop;
  logic           q_valid;
  logic           q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.area_x      <= '0;
      cfg.area_y      <= '0;
      cfg.area_width  <= '0;
      cfg.area_height <= '0;
      cfg.row_count   <= rgtl_pkg::CNT_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        rgtl_pkg::REG_AREA_X:      cfg.area_x      <= cfg_data;
        rgtl_pkg::REG_AREA_Y:      cfg.area_y      <= cfg_data;
        rgtl_pkg::REG_AREA_WIDTH:  cfg.area_width  <= cfg_data[rgtl_pkg::SIZE_W-1:0];
        rgtl_pkg::REG_AREA_HEIGHT: cfg.area_height <= cfg_data[rgtl_pkg::SIZE_W-1:0];
        rgtl_pkg::REG_ROW_COUNT:   cfg.row_count   <= cfg_data[rgtl_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rgtl_front u_front (
    .start      (start),
    .tile_count (tile_count),
    .row_count  (cfg.row_count),
    .queue_full (q_full),
    .busy       (busy),
    .push       (push),
    .cmd        (push_cmd)
  );

  rgtl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .valid    (q_valid),
    .full     (q_full),
    .head     (head)
  );

  rgtl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd_valid     (q_valid),
    .cmd           (head),
    .cmd_pop       (pop),
    .result_strobe (result_strobe),
    .tile_index    (tile_index),
    .tile_x        (tile_x),
    .tile_y        (tile_y),
    .tile_width    (tile_width),
    .tile_height   (tile_height),
    .is_last       (is_last)
  );

endmodule

// File: sv/rgtl_front.sv
// Front end of the tile layout block: takes items, clamps the tile count
// and the row count, and pushes one command per non-empty pass.
// Depends on rgtl_pkg.
module rgtl_front (
  input  logic                         start,
  input  logic [rgtl_pkg::CNT_W-1:0]   tile_count,
  input  logic [rgtl_pkg::CNT_W-1:0]   row_count,
  input  logic                         queue_full,
  output logic                         busy,
  output logic                         push,
  output rgtl_pkg::cmd_t               cmd
);

  logic [rgtl_pkg::CNT_W-1:0] tiles;

  always_comb begin
    if (tile_count > rgtl_pkg::CNT_W'(rgtl_pkg::MAX_TILES)) begin
      tiles = rgtl_pkg::CNT_W'(rgtl_pkg::MAX_TILES);
    end else begin
      tiles = tile_count;
    end
    cmd.tiles = tiles;
    if (row_count > tiles) begin
      cmd.rows = tiles;
    end else begin
      cmd.rows = row_count;
    end
  end

  assign busy = queue_full;
  assign push = start && !queue_full && (tiles != '0);

endmodule

// File: sv/rgtl_queue.sv
// Two-entry command queue between the front end and the sequencer.
// Depends on rgtl_pkg.
module rgtl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rgtl_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           valid,
  output logic           full,
  output rgtl_pkg::cmd_t head
);

  rgtl_pkg::cmd_t                  slots [rgtl_pkg::QUEUE_DEPTH];
  logic [rgtl_pkg::QPTR_W-1:0]     wr_ptr;
  logic [rgtl_pkg::QPTR_W-1:0]     rd_ptr;
  logic [rgtl_pkg::QCNT_W-1:0]     count;

  assign valid = (count != '0);
  assign full  = (count == rgtl_pkg::QCNT_W'(rgtl_pkg::QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");

endmodule

// File: sv/rgtl_div.sv
// Shared restoring divider, one quotient bit per cycle.
// A zero divisor yields zero quotient and zero remainder.
// Depends on rgtl_pkg.
module rgtl_div (
  input  logic               clk,
  input  logic               rst,
  input  rgtl_pkg::div_req_t req,
  output rgtl_pkg::div_rsp_t rsp
);

  logic                            active;
  logic                            done;
  logic                            zero_div;
  logic [rgtl_pkg::DIV_CNT_W-1:0]  cnt;
  logic [rgtl_pkg::DSR_W-1:0]      dsr;
  logic [rgtl_pkg::DSR_W-1:0]      rem;
  logic [rgtl_pkg::DIV_W-1:0]      quo;

  logic [rgtl_pkg::DSR_W:0]        trial;
  logic [rgtl_pkg::DSR_W:0]        diff;
  logic                            fits;

  always_comb begin
    trial = {rem, quo[rgtl_pkg::DIV_W-1]};
    fits  = (trial >= {1'b0, dsr});
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dsr      <= req.divisor;
      zero_div <= (req.divisor == '0);
      rem      <= '0;
      quo      <= req.dividend;
    end else if (active) begin
      rem <= fits ? diff[rgtl_pkg::DSR_W-1:0] : trial[rgtl_pkg::DSR_W-1:0];
      quo <= {quo[rgtl_pkg::DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= active && (cnt == rgtl_pkg::DIV_CNT_W'(1));
      if (req.start) begin
        active <= 1'b1;
        cnt    <= rgtl_pkg::DIV_CNT_W'(rgtl_pkg::DIV_STEPS);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == rgtl_pkg::DIV_CNT_W'(1)) begin
          active <= 1'b0;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = zero_div ? '0 : quo;
  assign rsp.remainder = zero_div ? '0 : rem;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!active && !$past(req.start)))
    else $error("divider done while a division is still running");

endmodule

// File: sv/rgtl_back.sv
// Sequencer of the tile layout block: runs the four splits of a pass on the
// shared divider, then emits one tile per cycle. Instantiates rgtl_div.
// Depends on rgtl_pkg.
module rgtl_back (
  input  logic                            clk,
  input  logic                            rst,
  input  rgtl_pkg::cfg_t                  cfg,
  input  logic                            cmd_valid,
  input  rgtl_pkg::cmd_t                  cmd,
  output logic                            cmd_pop,
  output logic                            result_strobe,
  output logic [rgtl_pkg::IDX_W-1:0]      tile_index,
  output logic signed [rgtl_pkg::POS_W-1:0] tile_x,
  output logic signed [rgtl_pkg::POS_W-1:0] tile_y,
  output logic [rgtl_pkg::SIZE_W-1:0]     tile_width,
  output logic [rgtl_pkg::SIZE_W-1:0]     tile_height,
  output logic                            is_last
);

  rgtl_pkg::back_state_t state, state_next;
  rgtl_pkg::div_req_t    div_req;
  rgtl_pkg::div_rsp_t    div_rsp;

  logic [rgtl_pkg::CNT_W-1:0]   rows;
  logic [rgtl_pkg::CNT_W-1:0]   tiles_left;
  logic [rgtl_pkg::CNT_W-1:0]   per_min;
  logic [rgtl_pkg::CNT_W-1:0]   per_max;
  logic [rgtl_pkg::CNT_W-1:0]   long_rows;
  logic [rgtl_pkg::SIZE_W-1:0]  q_wmax;
  logic [rgtl_pkg::CNT_W-1:0]   r_wmax;
  logic [rgtl_pkg::SIZE_W-1:0]  q_wmin;
  logic [rgtl_pkg::CNT_W-1:0]   r_wmin;
  logic [rgtl_pkg::SIZE_W-1:0]  q_h;
  logic [rgtl_pkg::CNT_W-1:0]   r_h;
  logic [rgtl_pkg::CNT_W-1:0]   row_index;
  logic [rgtl_pkg::CNT_W-1:0]   col_index;
  logic [rgtl_pkg::COORD_W-1:0] x_carry;
  logic [rgtl_pkg::POS_W-1:0]   y_cursor;
  logic [rgtl_pkg::IDX_W-1:0]   tile_count_out;

  logic                         is_long;
  logic [rgtl_pkg::CNT_W-1:0]   in_row;
  logic [rgtl_pkg::CNT_W-1:0]   col_next;
  logic                         row_end;
  logic [rgtl_pkg::SIZE_W-1:0]  w;
  logic [rgtl_pkg::SIZE_W-1:0]  h;
  logic [rgtl_pkg::CNT_W-1:0]   split_per_max;

  rgtl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign split_per_max = div_rsp.quotient[rgtl_pkg::CNT_W-1:0]
                       + rgtl_pkg::CNT_W'(div_rsp.remainder != '0);

  always_comb begin
    state_next = state;
    case (state)
      rgtl_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = rgtl_pkg::ST_DIV_N;
        end
      end
      rgtl_pkg::ST_DIV_N: begin
        if (div_rsp.done) begin
          state_next = rgtl_pkg::ST_DIV_WMAX;
        end
      end
      rgtl_pkg::ST_DIV_WMAX: begin
        if (div_rsp.done) begin
          state_next = rgtl_pkg::ST_DIV_WMIN;
        end
      end
      rgtl_pkg::ST_DIV_WMIN: begin
        if (div_rsp.done) begin
          state_next = rgtl_pkg::ST_DIV_H;
        end
      end
      rgtl_pkg::ST_DIV_H: begin
        if (div_rsp.done) begin
          state_next = rgtl_pkg::ST_EMIT;
        end
      end
      rgtl_pkg::ST_EMIT: begin
        if (tiles_left == rgtl_pkg::CNT_W'(1)) begin
          state_next = rgtl_pkg::ST_IDLE;
        end
      end
      default: state_next = rgtl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = cfg.area_width;
    div_req.divisor  = per_min;
    case (state)
      rgtl_pkg::ST_IDLE: begin
        cmd_pop          = cmd_valid;
        div_req.start    = cmd_valid;
        div_req.dividend = rgtl_pkg::DIV_W'(cmd.tiles);
        div_req.divisor  = cmd.rows;
      end
      rgtl_pkg::ST_DIV_N: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = cfg.area_width;
        div_req.divisor  = split_per_max;
      end
      rgtl_pkg::ST_DIV_WMAX: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = cfg.area_width;
        div_req.divisor  = per_min;
      end
      rgtl_pkg::ST_DIV_WMIN: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = cfg.area_height;
        div_req.divisor  = rows;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    is_long  = (row_index < long_rows);
    in_row   = is_long ? per_max : per_min;
    col_next = col_index + 1'b1;
    row_end  = (col_next >= in_row);
    h        = q_h + rgtl_pkg::SIZE_W'(row_index < r_h);
    if (is_long) begin
      w = q_wmax + rgtl_pkg::SIZE_W'(col_index < r_wmax);
    end else begin
      w = q_wmin + rgtl_pkg::SIZE_W'(col_index < r_wmin);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rgtl_pkg::ST_IDLE;
      result_strobe <= 1'b0;
      tiles_left    <= '0;
    end else begin
      state         <= state_next;
      result_strobe <= (state == rgtl_pkg::ST_EMIT);
      if (state == rgtl_pkg::ST_IDLE && cmd_valid) begin
        tiles_left <= cmd.tiles;
      end else if (state == rgtl_pkg::ST_EMIT) begin
        tiles_left <= tiles_left - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rgtl_pkg::ST_IDLE: begin
        rows <= cmd.rows;
      end
      rgtl_pkg::ST_DIV_N: begin
        if (div_rsp.done) begin
          per_min   <= div_rsp.quotient[rgtl_pkg::CNT_W-1:0];
          long_rows <= div_rsp.remainder;
          per_max   <= split_per_max;
        end
      end
      rgtl_pkg::ST_DIV_WMAX: begin
        if (div_rsp.done) begin
          q_wmax <= div_rsp.quotient;
          r_wmax <= div_rsp.remainder;
        end
      end
      rgtl_pkg::ST_DIV_WMIN: begin
        if (div_rsp.done) begin
          q_wmin <= div_rsp.quotient;
          r_wmin <= div_rsp.remainder;
        end
      end
      rgtl_pkg::ST_DIV_H: begin
        if (div_rsp.done) begin
          q_h            <= div_rsp.quotient;
          r_h            <= div_rsp.remainder;
          row_index      <= '0;
          col_index      <= '0;
          x_carry        <= '0;
          y_cursor       <= {cfg.area_y[rgtl_pkg::COORD_W-1], cfg.area_y};
          tile_count_out <= '0;
        end
      end
      rgtl_pkg::ST_EMIT: begin
        tile_index     <= tile_count_out;
        tile_x         <= $signed({cfg.area_x[rgtl_pkg::COORD_W-1], cfg.area_x})
                        + $signed({1'b0, x_carry});
        tile_y         <= $signed(y_cursor);
        tile_width     <= w;
        tile_height    <= h;
        is_last        <= (tiles_left == rgtl_pkg::CNT_W'(1));
        tile_count_out <= tile_count_out + 1'b1;
        if (row_end) begin
          col_index <= '0;
          x_carry   <= '0;
          y_cursor  <= y_cursor + rgtl_pkg::POS_W'(h);
          row_index <= row_index + 1'b1;
        end else begin
          col_index <= col_next;
          x_carry   <= x_carry + rgtl_pkg::COORD_W'(w);
        end
      end
      default: begin
      end
    endcase
  end

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> ($past(state) == rgtl_pkg::ST_EMIT))
    else $error("result strobe outside the emit phase");

  a_last_ends_pass: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && is_last) |-> (state == rgtl_pkg::ST_IDLE))
    else $error("last tile emitted but the sequencer kept emitting");

  a_tiles_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !is_last) |=> result_strobe)
    else $error("gap inside the tiles of one pass");

endmodule

// File: test/rgtl_layout_mon.sv
// Monitor and scoreboard for the rectangle tile layout block.
// Tracks register writes, predicts the tiles of every accepted item and compares
// them with the tile port; depends on rgtl_pkg only.
module rgtl_layout_mon
  import rgtl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DAT_W-1:0]      cfg_data,
  input  logic                      start,
  input  logic                      busy,
  input  logic [CNT_W-1:0]          tile_count,
  input  logic                      result_strobe,
  input  logic [IDX_W-1:0]          tile_index,
  input  logic signed [POS_W-1:0]   tile_x,
  input  logic signed [POS_W-1:0]   tile_y,
  input  logic [SIZE_W-1:0]         tile_width,
  input  logic [SIZE_W-1:0]         tile_height,
  input  logic                      is_last,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [IDX_W-1:0]        num;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
    logic                    last;
  } tile_t;

  tile_t tiles_due[$];
  int mismatch_count = 0;

  logic [COORD_W-1:0] x_cfg;
  logic [COORD_W-1:0] y_cfg;
  logic [SIZE_W-1:0]  width_cfg;
  logic [SIZE_W-1:0]  height_cfg;
  logic [CNT_W-1:0]   rows_cfg;

  assign errors = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatch_count++;
  endtask

  // Splits the configured area into rows and columns the way the block does.
  function automatic void plan_tiles(input logic [CNT_W-1:0] count);
    int n, rows, per_min, long_rows, per_max;
    int wq_long, wr_long, wq_short, wr_short, hq, hr;
    int row, col, in_row, w, h, y, x0;
    logic [COORD_W-1:0] x_run;
    bit long_row;
    tile_t t;
    n = int'(count);
    if (n > MAX_TILES) n = MAX_TILES;
    rows = int'(rows_cfg);
    if (n != 0 && rows > n) rows = n;
    per_min   = (rows != 0) ? n / rows : 0;
    long_rows = (rows != 0) ? n % rows : 0;
    per_max   = per_min + (long_rows != 0);
    wq_long   = (per_max != 0) ? int'(width_cfg) / per_max : 0;
    wr_long   = (per_max != 0) ? int'(width_cfg) % per_max : 0;
    wq_short  = (per_min != 0) ? int'(width_cfg) / per_min : 0;
    wr_short  = (per_min != 0) ? int'(width_cfg) % per_min : 0;
    hq        = (rows != 0) ? int'(height_cfg) / rows : 0;
    hr        = (rows != 0) ? int'(height_cfg) % rows : 0;
    x0 = int'($signed(x_cfg));
    y  = int'($signed(y_cfg));
    row = 0;
    col = 0;
    x_run = '0;
    for (int k = 0; k < n; k++) begin
      long_row = row < long_rows;
      in_row = long_row ? per_max : per_min;
      h = hq + (row < hr);
      w = long_row ? wq_long + (col < wr_long) : wq_short + (col < wr_short);
      t.num  = IDX_W'(k);
      t.x    = POS_W'(x0 + int'(x_run));
      t.y    = POS_W'(y);
      t.w    = SIZE_W'(w);
      t.h    = SIZE_W'(h);
      t.last = (k == n - 1);
      tiles_due.push_back(t);
      x_run = COORD_W'(int'(x_run) + w);
      col++;
      if (col >= in_row) begin
        col = 0;
        x_run = '0;
        y += h;
        row++;
      end
    end
  endfunction

  always @(posedge clk) begin
    tile_t want;
    if (rst) begin
      x_cfg      = '0;
      y_cfg      = '0;
      width_cfg  = '0;
      height_cfg = '0;
      rows_cfg   = CNT_W'(1);
      tiles_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_AREA_X:      x_cfg      = cfg_data[COORD_W-1:0];
          REG_AREA_Y:      y_cfg      = cfg_data[COORD_W-1:0];
          REG_AREA_WIDTH:  width_cfg  = cfg_data[SIZE_W-1:0];
          REG_AREA_HEIGHT: height_cfg = cfg_data[SIZE_W-1:0];
          REG_ROW_COUNT:   rows_cfg   = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) plan_tiles(tile_count);
      if (result_strobe) begin
        if (tiles_due.size() == 0) begin
          report_mismatch($sformatf("tile %0d arrived with none outstanding", tile_index));
        end else begin
          want = tiles_due.pop_front();
          if (tile_index !== want.num)
            report_mismatch($sformatf("tile_index got %0d want %0d", tile_index, want.num));
          if (tile_x !== want.x)
            report_mismatch($sformatf("tile %0d: tile_x got %0d want %0d",
                                      want.num, tile_x, want.x));
          if (tile_y !== want.y)
            report_mismatch($sformatf("tile %0d: tile_y got %0d want %0d",
                                      want.num, tile_y, want.y));
          if (tile_width !== want.w)
            report_mismatch($sformatf("tile %0d: tile_width got %0d want %0d",
                                      want.num, tile_width, want.w));
          if (tile_height !== want.h)
            report_mismatch($sformatf("tile %0d: tile_height got %0d want %0d",
                                      want.num, tile_height, want.h));
          if (is_last !== want.last)
            report_mismatch($sformatf("tile %0d: is_last got %0b want %0b",
                                      want.num, is_last, want.last));
        end
      end
    end
    pending <= tiles_due.size();
  end

endmodule

// File: test/tb.sv
// Top of the rectangle tile layout testbench: clock, reset, register writes and
// tile count stimulus in bursts, watchdog and verdict.
// Depends on rgtl_pkg, rect_grid_tile_layout and rgtl_layout_mon.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rgtl_pkg::*;

  localparam int NUM_REGS     = 5;
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT  = 3000;

  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    cfg_write  = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_DAT_W-1:0]    cfg_data   = '0;
  logic                    start      = 1'b0;
  logic [CNT_W-1:0]        tile_count = '0;
  logic                    busy;
  logic                    result_strobe;
  logic [IDX_W-1:0]        tile_index;
  logic signed [POS_W-1:0] tile_x;
  logic signed [POS_W-1:0] tile_y;
  logic [SIZE_W-1:0]       tile_width;
  logic [SIZE_W-1:0]       tile_height;
  logic                    is_last;
  int                      errors;
  int                      pending;
  int                      quiet_cycles = 0;

  always #4 clk = ~clk;

  rect_grid_tile_layout dut (.*);

  rgtl_layout_mon layout_mon (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** rect_grid_tile_layout: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Narrow registers get random upper bits, which the block must drop.
  task automatic configure(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input logic [CNT_W-1:0] rows);
    write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
              CFG_DAT_W'($urandom));
    write_reg(REG_AREA_X, x);
    write_reg(REG_AREA_Y, y);
    write_reg(REG_AREA_WIDTH, {1'($urandom), w});
    write_reg(REG_AREA_HEIGHT, {1'($urandom), h});
    write_reg(REG_ROW_COUNT, {9'($urandom), rows});
    cfg_write <= 1'b0;
  endtask

  task automatic send_item(input logic [CNT_W-1:0] cnt);
    start      <= 1'b1;
    tile_count <= cnt;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start      <= 1'b0;
      tile_count <= CNT_W'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CNT_W-1:0] random_count();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return CNT_W'($urandom_range(MAX_TILES + 1, (1 << CNT_W) - 1));
    if (pick < 12) return CNT_W'($urandom_range(1, 12));
    return CNT_W'($urandom_range(13, MAX_TILES));
  endfunction

  function automatic logic [SIZE_W-1:0] random_extent();
    if ($urandom_range(0, 2) == 0) return SIZE_W'($urandom);
    return SIZE_W'($urandom_range(0, 300));
  endfunction

  function automatic logic [CNT_W-1:0] random_rows();
    if ($urandom_range(0, 3) == 0) return CNT_W'($urandom_range(0, MAX_TILES));
    return CNT_W'($urandom_range(1, 9));
  endfunction

  task automatic random_items(input int total);
    int left;
    int burst;
    left = total;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && left > 0) begin
        send_item(random_count());
        burst--;
        left--;
      end
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at their reset values: zero-sized area, one row.
    send_item(CNT_W'(0));
    send_item(CNT_W'(1));
    pause_sender(3);
    send_item(CNT_W'(5));
    settle();

    // Most negative origin, largest area, 64 rows; a count above the limit saturates.
    configure(16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF, CNT_W'(MAX_TILES));
    send_item(CNT_W'(MAX_TILES));
    send_item(CNT_W'((1 << CNT_W) - 1));
    pause_sender(7);
    send_item(CNT_W'(MAX_TILES - 1));
    settle();

    // Zero rows put every tile at the origin with no size.
    configure(16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF, '0);
    send_item(CNT_W'(4));
    send_item(CNT_W'(0));
    send_item(CNT_W'(MAX_TILES));
    settle();

    // Uneven split: long rows, wide tiles and tall rows, and a row count clamped.
    configure(16'hFFFB, 16'd7, 15'd100, 15'd50, 7'd7);
    send_item(CNT_W'(10));
    send_item(CNT_W'(7));
    pause_sender(1);
    send_item(CNT_W'(22));
    send_item(CNT_W'(3));
    send_item(CNT_W'(1));
    settle();

    // Small area, so every tile comes out three pixels wide and zero or one pixel tall.
    configure(16'd0, 16'd0, 15'd3, 15'd1, CNT_W'(MAX_TILES));
    send_item(CNT_W'(MAX_TILES));
    send_item(CNT_W'(MAX_TILES + 1));
    settle();

    repeat (8) begin
      configure(COORD_W'($urandom), COORD_W'($urandom), random_extent(), random_extent(),
                random_rows());
      random_items(14);
      settle();
    end

    if (errors == 0) begin
      $display("** rect_grid_tile_layout: PASSED **");
    end else begin
      $display("** rect_grid_tile_layout: FAILED **");
    end
    $finish;
  end

endmodule
